@@ design/drac_pkg.sv @@
// Shared types, constants and a decode helper for the duplicate request answer cache.
package drac_pkg;

    localparam int CACHE_ENTRIES_DEF = 8;

    localparam int SLOT_W     = 3;
    localparam int LEN_W      = 11;
    localparam int META_W     = 4;
    localparam int WRITE_BIT  = 15;
    localparam int META_SHIFT = 13;
    localparam logic [15:0] META_TABLE = 16'h8420;

    // Request key as it arrives; the same layout is what a cache entry holds.
    typedef struct packed {
        logic [31:0]      src_ip;
        logic [15:0]      src_port;
        logic [15:0]      request_id;
        logic [15:0]      command_word;
        logic [15:0]      object_index;
        logic [31:0]      byte_offset;
        logic [LEN_W-1:0] packet_length;
    } t_req;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              is_write;
        logic [LEN_W-1:0]  length_field;
        logic [META_W-1:0] meta_length;
    } t_rsp;

    // Metadata size code 0..3 maps to 0, 2, 4 or 8 bytes.
    function automatic logic [META_W-1:0] meta_decode(input logic [15:0] cmd);
        logic [15:0] shifted;
        shifted = META_TABLE >> {cmd[META_SHIFT+1:META_SHIFT], 2'b00};
        return shifted[META_W-1:0];
    endfunction

endpackage

@@ design/drac_store.sv @@
// Entry memory with one write port, one registered read port and per-entry valid bits.
module drac_store import drac_pkg::*; #(
    parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF,
    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_req             i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output t_req             o_rdata,
    output logic             o_rvalid
);

    t_req                     r_mem [CACHE_ENTRIES];
    logic [CACHE_ENTRIES-1:0] r_valid;
    t_req                     r_rdata;
    logic                     r_rvalid;

    // Key storage: no reset, entries are qualified by their valid bit.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rvalid <= r_valid[i_raddr];
        end
    end

    assign o_rdata  = r_rdata;
    assign o_rvalid = r_rvalid;

endmodule

@@ design/drac_match.sv @@
// Shared key comparator: checks one stored entry against the held request.
module drac_match import drac_pkg::*; (
    input  t_req i_key,
    input  t_req i_entry,
    input  logic i_entry_valid,
    output logic o_match
);

    // An empty entry never matches, even on an all-zero key.
    assign o_match = i_entry_valid && (i_entry == i_key);

endmodule

@@ design/duplicate_request_answer_cache_core.sv @@
// Top level of the duplicate request answer cache: scan sequencer and result register.
//
// Usage:
//   Drive a request key on i_req and raise start while busy is low; the key is
//   taken at that clock edge and busy goes high on the next cycle.
//   The sequencer walks the entry memory one slot per cycle through a single
//   comparator. The lowest valid slot whose key matches is a hit; when no slot
//   matches, the slot at the round-robin victim pointer is overwritten with the
//   key, marked valid, and the pointer advances with wraparound.
//   o_done pulses for exactly one cycle with the result on o_rsp: hit flag,
//   slot, and the decoded command word (write flag, length, metadata bytes).
//   A hit ends the scan at the matching slot; a miss ends it after the last
//   slot. Each slot passes through the memory read register and then the
//   comparator, and the result is registered with o_done.
//   busy drops in the cycle that shows the result, so a new request may be
//   transferred then; a request is not taken until the previous result is shown.
//   The receiver cannot stall: a result not taken in its strobe cycle is gone.
//   Reset (synchronous, active low) clears all valid bits and the victim
//   pointer and returns the sequencer to idle; stored keys are not cleared.
module duplicate_request_answer_cache_core import drac_pkg::*; #(
    parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_done,
    output t_rsp o_rsp
);

    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state           r_state,   n_state;
    logic [IDX_W-1:0] r_idx,     n_idx;
    logic             r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0] r_cmp_idx;
    logic [IDX_W-1:0] r_victim,  n_victim;
    logic             r_done,    n_done;
    t_req             r_req;
    t_rsp             r_rsp;

    t_req             w_rdata;
    logic             w_rvalid;
    logic             w_match;
    logic             w_accept;
    logic             w_last;
    logic             w_finish;
    logic             w_alloc;
    logic [IDX_W-1:0] w_slot;

    // Entry memory; reads are issued at r_idx and land in the next cycle.
    drac_store #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (w_alloc),
        .i_waddr  (r_victim),
        .i_wdata  (r_req),
        .i_raddr  (r_idx),
        .o_rdata  (w_rdata),
        .o_rvalid (w_rvalid)
    );

    drac_match u_match (
        .i_key         (r_req),
        .i_entry       (w_rdata),
        .i_entry_valid (w_rvalid),
        .o_match       (w_match)
    );

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_last   = (r_cmp_idx == LAST_IDX);
    // Scan ends on the first match (lowest slot) or after the last slot is checked.
    assign w_finish = (r_state == S_SCAN) && r_cmp_vld && (w_match || w_last);
    assign w_alloc  = w_finish && !w_match;
    assign w_slot   = w_match ? r_cmp_idx : r_victim;

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_cmp_vld = 1'b0;
        n_victim  = r_victim;
        n_done    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SCAN;
                    n_idx   = '0;
                end
            end
            S_SCAN: begin
                // Advance the read address every cycle; the compare sees it through the read register and r_cmp_idx.
                n_idx     = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
                n_cmp_vld = !w_finish;
                if (w_finish) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                    if (w_alloc) begin
                        n_victim = (r_victim == LAST_IDX) ? '0 : r_victim + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_victim  <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_cmp_vld <= n_cmp_vld;
            r_victim  <= n_victim;
            r_done    <= n_done;
        end
    end

    // Payload registers: hold the key for the scan, capture the result on finish.
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_idx;
        if (w_accept) begin
            r_req <= i_req;
        end
        if (w_finish) begin
            r_rsp.hit          <= w_match;
            r_rsp.slot         <= SLOT_W'(w_slot);
            r_rsp.is_write     <= r_req.command_word[WRITE_BIT];
            r_rsp.length_field <= r_req.command_word[LEN_W-1:0];
            r_rsp.meta_length  <= meta_decode(r_req.command_word);
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

`ifndef NO_ASSERTIONS
    // A result only follows a scan cycle.
    a_done_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_SCAN))
        else $error("result strobe without a preceding scan");

    // The result is shown while the sequencer is already idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // Compare data is only live during a scan.
    a_cmp_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> (r_state == S_SCAN))
        else $error("compare stage live outside scan");

    // The victim pointer moves only on an allocating finish.
    a_victim_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_alloc |=> $stable(r_victim))
        else $error("victim pointer moved without allocation");
`endif

endmodule
